FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table: operation and status codes,
// sequencer states and the per-cell control word.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 3;
	localparam int ENTRY_BITS  = 6;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LIST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_DELETED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_ENTRY     = 3'd4,
		STAT_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CMP   = 4'b0010,
		S_APPLY = 4'b0100,
		S_LIST  = 4'b1000
	} state_t;

	// what every cell does to its entry
	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_ROTATE = 2'd3
	} cell_act_t;

	typedef struct packed {
		cell_act_t act;
		logic      capture;
	} cell_ctrl_t;

endpackage

FILE: rtl/skt_if.sv
// ----------------------------------------------------------------------------
// skt_req_if / skt_rsp_if
// Valid/ready channels of the sorted key table: command in, result out.
// ----------------------------------------------------------------------------
interface skt_req_if #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              operation;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, output operation, output key, output payload, input ready);
	modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

interface skt_rsp_if #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [2:0]              status;
	logic [KEY_BITS-1:0]     key_out;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic [5:0]              entry_count;
	logic                    last;

	modport source (output valid, output status, output key_out, output payload_out,
		output entry_count, output last, input ready);
	modport sink   (input valid, input status, input key_out, input payload_out,
		input entry_count, input last, output ready);
endinterface

FILE: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the table: holds a key and payload, compares against the
// broadcast key and moves its entry to or from its neighbors.
// ----------------------------------------------------------------------------
module skt_cell #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  skt_pkg::cell_ctrl_t     ctrl,
	input  logic                    occupied,
	input  logic                    is_tail,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_pay,
	input  logic [KEY_BITS-1:0]     prev_key,
	input  logic [PAYLOAD_BITS-1:0] prev_pay,
	input  logic                    prev_gt,
	input  logic                    prev_hit,
	input  logic [KEY_BITS-1:0]     next_key,
	input  logic [PAYLOAD_BITS-1:0] next_pay,
	input  logic [KEY_BITS-1:0]     head_key,
	input  logic [PAYLOAD_BITS-1:0] head_pay,
	output logic [KEY_BITS-1:0]     key_q,
	output logic [PAYLOAD_BITS-1:0] pay_q,
	output logic                    gt,
	output logic                    hit,
	output logic                    first
);
	import skt_pkg::*;

	logic gt_q;
	logic match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q    <= 1'b0;
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			gt_q    <= occupied && (key_q > new_key);
			match_q <= occupied && (key_q == new_key);
		end
	end

	assign gt    = gt_q;
	// hit: a match at this cell or anywhere ahead of it
	assign hit   = prev_hit | match_q;
	assign first = match_q & ~prev_hit;

	always_ff @(posedge clk) begin
		case (ctrl.act)
			ACT_INSERT: begin
				if (!gt_q) begin
					if (prev_gt) begin
						key_q <= new_key;
						pay_q <= new_pay;
					end else begin
						key_q <= prev_key;
						pay_q <= prev_pay;
					end
				end
			end
			ACT_DELETE: begin
				if (hit) begin
					key_q <= next_key;
					pay_q <= next_pay;
				end
			end
			ACT_ROTATE: begin
				if (occupied) begin
					if (is_tail) begin
						key_q <= head_key;
						pay_q <= head_pay;
					end else begin
						key_q <= next_key;
						pay_q <= next_pay;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/sorted_key_table_insert_delete_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_delete_top
// Table of up to DEPTH key/payload entries kept in descending key order in a
// chain of cells; insert, delete by key and in-order listing.
//
//   channel  dir  payload                                         handshake
//   req      in   operation, key, payload                         valid/ready
//   rsp      out  status, key_out, payload_out, entry_count, last valid/ready
//
// insert and delete hold the block from acceptance in S_IDLE through S_CMP,
// where every cell compares its key, to S_APPLY, where the chain shifts and
// the result is registered. a list goes from S_CMP to S_LIST, or to S_APPLY
// with an empty status when nothing is held; S_LIST rotates the chain by one
// cell per result and sends the head entry while rsp accepts. a stalled
// rsp stops the sequencer before it shifts; req is taken only when idle.
// reset clears the entry count, no sweep over the cells is needed.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_delete_top #(
	parameter int DEPTH        = 32,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t                  state_q;
	op_t                     op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;

	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic [KEY_BITS-1:0]     rsp_key_q;
	logic [PAYLOAD_BITS-1:0] rsp_pay_q;
	logic [ENTRY_BITS-1:0]   rsp_count_q;
	logic                    rsp_last_q;

	cell_ctrl_t              ctrl;
	logic [KEY_BITS-1:0]     cell_key [DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
	logic [DEPTH-1:0]        cell_gt;
	logic [DEPTH-1:0]        cell_hit;
	logic [DEPTH-1:0]        cell_first;
	logic [DEPTH-1:0]        occ;
	logic [DEPTH-1:0]        tail;

	logic                    out_free;
	logic                    emit;
	status_t                 emit_status;
	logic [KEY_BITS-1:0]     emit_key;
	logic [PAYLOAD_BITS-1:0] emit_pay;
	logic                    emit_last;
	logic [CW-1:0]           count_d;
	state_t                  state_d;
	logic [PAYLOAD_BITS-1:0] del_pay;
	logic                    list_end;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign list_end  = (idx_q == count_q - CW'(1));

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic [KEY_BITS-1:0]     p_key;
			logic [PAYLOAD_BITS-1:0] p_pay;
			logic                    p_gt;
			logic                    p_hit;
			logic [KEY_BITS-1:0]     n_key;
			logic [PAYLOAD_BITS-1:0] n_pay;

			assign occ[i]  = (CW'(i) < count_q);
			assign tail[i] = (CW'(i) == count_q - CW'(1));

			if (i == 0) begin : g_head
				assign p_key = key_q;
				assign p_pay = pay_q;
				assign p_gt  = 1'b1;
				assign p_hit = 1'b0;
			end else begin : g_body
				assign p_key = cell_key[i-1];
				assign p_pay = cell_pay[i-1];
				assign p_gt  = cell_gt[i-1];
				assign p_hit = cell_hit[i-1];
			end

			if (i == DEPTH - 1) begin : g_end
				assign n_key = cell_key[i];
				assign n_pay = cell_pay[i];
			end else begin : g_mid
				assign n_key = cell_key[i+1];
				assign n_pay = cell_pay[i+1];
			end

			skt_cell #(
				.KEY_BITS     (KEY_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.occupied (occ[i]),
				.is_tail  (tail[i]),
				.new_key  (key_q),
				.new_pay  (pay_q),
				.prev_key (p_key),
				.prev_pay (p_pay),
				.prev_gt  (p_gt),
				.prev_hit (p_hit),
				.next_key (n_key),
				.next_pay (n_pay),
				.head_key (cell_key[0]),
				.head_pay (cell_pay[0]),
				.key_q    (cell_key[i]),
				.pay_q    (cell_pay[i]),
				.gt       (cell_gt[i]),
				.hit      (cell_hit[i]),
				.first    (cell_first[i])
			);
		end
	endgenerate

	// payload of the first matching cell, one-hot select
	always_comb begin
		del_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			del_pay = del_pay | (cell_pay[i] & {PAYLOAD_BITS{cell_first[i]}});
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ctrl.act     = ACT_HOLD;
		ctrl.capture = 1'b0;
		emit         = 1'b0;
		emit_status  = STAT_INSERTED;
		emit_key     = '0;
		emit_pay     = '0;
		emit_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (req.valid && (op_t'(req.operation) != OP_NONE)) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.capture = 1'b1;
				if (op_q == OP_LIST && count_q != '0) begin
					state_d = S_LIST;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						OP_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								emit_status = STAT_FULL;
							end else begin
								ctrl.act    = ACT_INSERT;
								count_d     = count_q + CW'(1);
								emit_status = STAT_INSERTED;
							end
						end
						OP_DELETE: begin
							if (cell_hit[DEPTH-1]) begin
								ctrl.act    = ACT_DELETE;
								count_d     = count_q - CW'(1);
								emit_status = STAT_DELETED;
								emit_key    = key_q;
								emit_pay    = del_pay;
							end else begin
								emit_status = STAT_NOT_FOUND;
							end
						end
						default: begin
							emit_status = STAT_EMPTY;
						end
					endcase
				end
			end
			S_LIST: begin
				if (out_free) begin
					ctrl.act    = ACT_ROTATE;
					emit        = 1'b1;
					emit_status = STAT_ENTRY;
					emit_key    = cell_key[0];
					emit_pay    = cell_pay[0];
					emit_last   = list_end;
					if (list_end) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_CMP) begin
				idx_q <= '0;
			end else if (state_q == S_LIST && out_free) begin
				idx_q <= idx_q + CW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= op_t'(req.operation);
			key_q <= req.key;
			pay_q <= req.payload;
		end
		if (emit) begin
			rsp_status_q <= emit_status;
			rsp_key_q    <= emit_key;
			rsp_pay_q    <= emit_pay;
			rsp_count_q  <= ENTRY_BITS'(count_d);
			rsp_last_q   <= emit_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.key_out     = rsp_key_q;
	assign rsp.payload_out = rsp_pay_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.last        = rsp_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> count_q != '0)
		else $error("listing an empty table");

	a_first_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |-> $onehot0(cell_first))
		else $error("more than one first match in the chain");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrites a pending transaction");

endmodule

FILE: sim/tb_sorted_key_table_insert_delete_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table_insert_delete_top
// Self-checking bench for the sorted key table. A queue of commands feeds a
// valid/ready driver. Every accepted command runs through a shadow table that
// is kept in descending key order. A monitor checks each result against the
// oldest predicted one, while both sides idle at random and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_insert_delete_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int TABLE_DEPTH  = 32;
	localparam int RANDOM_ITEMS = 140;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [15:0] payload;
	} table_cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] key;
		logic [15:0] payload;
		logic [5:0]  count;
		logic        last;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	always #1 clk = ~clk;

	skt_req_if req ();
	skt_rsp_if rsp ();

	sorted_key_table_insert_delete_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow of the table contents, position 0 holds the largest key
	logic [31:0] shadow_key [TABLE_DEPTH];
	logic [15:0] shadow_payload [TABLE_DEPTH];
	int          held_count = 0;

	table_cmd_t    pending_cmds[$];
	table_result_t expected_results[$];
	logic [31:0]   key_pool [8];

	table_cmd_t    next_cmd;
	table_cmd_t    accepted_cmd;
	table_result_t rsp_seen;
	table_result_t rsp_want;

	int          send_gap;
	int          stall_left;
	int          mismatches = 0;
	int          random_left;
	int          items_accepted;
	int          hold_left;
	logic        hold_done;
	logic [15:0] cyc;
	wire         calm = (cyc[9:8] == 2'b11);

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 99) < 70)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic queue_cmd(input op_t op, input logic [31:0] k, input logic [15:0] p);
		table_cmd_t c;
		c.op = op;
		c.key = k;
		c.payload = p;
		pending_cmds.push_back(c);
		if (op != OP_NONE)
			random_left--;
	endtask

	task automatic add_result(input status_t s, input logic [31:0] k, input logic [15:0] p,
			input logic fin);
		table_result_t r;
		r.status = s;
		r.key = k;
		r.payload = p;
		r.count = held_count[5:0];
		r.last = fin;
		expected_results.push_back(r);
	endtask

	task automatic predict_table_op(input table_cmd_t c);
		int pos;
		logic [31:0] dk;
		logic [15:0] dp;
		case (c.op)
			OP_INSERT: begin
				if (held_count >= TABLE_DEPTH) begin
					add_result(STAT_FULL, '0, '0, 1'b1);
				end else begin
					// equal keys go in front of the ones already held
					pos = 0;
					while (pos < held_count && shadow_key[pos] > c.key)
						pos++;
					for (int i = held_count; i > pos; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_payload[i] = shadow_payload[i-1];
					end
					shadow_key[pos] = c.key;
					shadow_payload[pos] = c.payload;
					held_count++;
					add_result(STAT_INSERTED, '0, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				pos = 0;
				while (pos < held_count && shadow_key[pos] != c.key)
					pos++;
				if (pos >= held_count) begin
					add_result(STAT_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					dk = shadow_key[pos];
					dp = shadow_payload[pos];
					for (int i = pos; i + 1 < held_count; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_payload[i] = shadow_payload[i+1];
					end
					held_count--;
					add_result(STAT_DELETED, dk, dp, 1'b1);
				end
			end
			OP_LIST: begin
				if (held_count == 0)
					add_result(STAT_EMPTY, '0, '0, 1'b1);
				for (int i = 0; i < held_count; i++)
					add_result(STAT_ENTRY, shadow_key[i], shadow_payload[i], i + 1 == held_count);
			end
			default: ;
		endcase
	endtask

	// driver: predict at the edge that takes the transaction, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= OP_INSERT;
			req.key <= '0;
			req.payload <= '0;
			items_accepted <= 0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				accepted_cmd.op = op_t'(req.operation);
				accepted_cmd.key = req.key;
				accepted_cmd.payload = req.payload;
				predict_table_op(accepted_cmd);
				items_accepted <= items_accepted + 1;
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					req.valid <= 1'b1;
					req.operation <= next_cmd.op;
					req.key <= next_cmd.key;
					req.payload <= next_cmd.payload;
					send_gap = pick_gap(calm);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off on the result side once the run is well under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
			cyc <= '0;
		end else begin
			cyc <= cyc + 1'b1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && items_accepted >= 70) begin
				hold_left <= 300;
				hold_done <= 1'b1;
			end
		end
	end

	// monitor and result-side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_seen.status = status_t'(rsp.status);
				rsp_seen.key = rsp.key_out;
				rsp_seen.payload = rsp.payload_out;
				rsp_seen.count = rsp.entry_count;
				rsp_seen.last = rsp.last;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d key %h payload %h count %0d last %b",
							rsp_seen.status, rsp_seen.key, rsp_seen.payload, rsp_seen.count,
							rsp_seen.last);
				end else begin
					rsp_want = expected_results.pop_front();
					if (rsp_seen.status !== rsp_want.status || rsp_seen.key !== rsp_want.key ||
							rsp_seen.payload !== rsp_want.payload ||
							rsp_seen.count !== rsp_want.count || rsp_seen.last !== rsp_want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected status %0d key %h payload %h count %0d last %b",
								rsp_want.status, rsp_want.key, rsp_want.payload, rsp_want.count,
								rsp_want.last);
							$display("          got      status %0d key %h payload %h count %0d last %b",
								rsp_seen.status, rsp_seen.key, rsp_seen.payload, rsp_seen.count,
								rsp_seen.last);
						end
					end
				end
			end
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap(calm);
			end
		end
	end

	initial begin
		int r;
		logic first;
		arst_n = 1'b0;

		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h0000_0001;
		for (int i = 4; i < 8; i++)
			key_pool[i] = $urandom;

		// directed: empty table, extremes, ties, first-match delete, unused selector
		random_left = 0;
		queue_cmd(OP_LIST, 32'h0, 16'h0);
		queue_cmd(OP_DELETE, 32'h5, 16'h0);
		queue_cmd(OP_INSERT, 32'h0000_0000, 16'h0000);
		queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		queue_cmd(OP_INSERT, 32'h0000_1000, 16'h0001);
		queue_cmd(OP_INSERT, 32'h0000_1000, 16'h0002);
		queue_cmd(OP_INSERT, 32'h0000_1000, 16'h0003);
		queue_cmd(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		queue_cmd(OP_INSERT, 32'h7FFF_FFFF, 16'h8000);
		queue_cmd(OP_LIST, 32'h0, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_1000, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_0000, 16'h0);
		queue_cmd(OP_DELETE, 32'h0001_2345, 16'h0);
		queue_cmd(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		queue_cmd(OP_LIST, 32'h0, 16'h0);
		queue_cmd(OP_DELETE, 32'hFFFF_FFFF, 16'h0);
		queue_cmd(OP_DELETE, 32'h7FFF_FFFF, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_1000, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_1000, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_0000, 16'h0);
		queue_cmd(OP_LIST, 32'h0, 16'h0);
		queue_cmd(OP_DELETE, 32'h0000_0000, 16'h0);
		queue_cmd(OP_INSERT, 32'h8000_0000, 16'hAAAA);
		queue_cmd(OP_INSERT, 32'h0000_0001, 16'h5555);
		queue_cmd(OP_LIST, 32'h0, 16'h0);

		// random phases: fill past full, drain, mixed traffic and some noise
		random_left = RANDOM_ITEMS;
		first = 1'b1;
		while (random_left > 0) begin
			case (first ? 0 : $urandom_range(0, 4))
				0: begin
					repeat (38) queue_cmd(OP_INSERT, pick_key(), 16'($urandom));
					queue_cmd(OP_LIST, $urandom, 16'($urandom));
				end
				1: begin
					repeat (24) queue_cmd(OP_DELETE, pick_key(), 16'($urandom));
					queue_cmd(OP_LIST, $urandom, 16'($urandom));
				end
				4: begin
					repeat (8) queue_cmd(op_t'($urandom_range(0, 3)), $urandom,
						16'($urandom));
				end
				default: begin
					repeat (20) begin
						r = $urandom_range(0, 99);
						if (r < 50)
							queue_cmd(OP_INSERT, pick_key(), 16'($urandom));
						else if (r < 80)
							queue_cmd(OP_DELETE, pick_key(), 16'($urandom));
						else if (r < 95)
							queue_cmd(OP_LIST, $urandom, 16'($urandom));
						else
							queue_cmd(OP_NONE, $urandom, 16'($urandom));
					end
				end
			endcase
			first = 1'b0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || req.valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		// a full list plus pipeline depth
		repeat (60) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
